// ----- hw/rtl/tcw_pkg.sv -----
// Shared types, codes and constants of the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // memory write source selected by the controller
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_CLEAR = 3'd1;
  localparam logic [2:0] WR_COPY  = 3'd2;
  localparam logic [2:0] WR_FILL  = 3'd3;
  localparam logic [2:0] WR_CHAR  = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic       latch_req;
    logic [2:0] wr_sel;
    logic       rd_req;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       brk_line;
    logic       scroll_start;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic col_full;
    logic line_last;
    logic cnt_copy_last;
    logic cnt_last;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
`default_nettype none
module tcw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire tcw_pkg::status_t sts,
  output tcw_pkg::cmd_t        cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wr_sel = WR_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_sel = WR_CLEAR;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_read) begin
          cmd.rd_req = 1'b1;
          state_nxt  = S_EMIT;
        end else if (sts.is_newline || sts.col_full) begin
          if (sts.line_last) begin
            cmd.scroll_start = 1'b1;
            cmd.cnt_clr      = 1'b1;
            state_nxt        = S_COPY;
          end else begin
            cmd.brk_line = 1'b1;
            state_nxt    = sts.is_newline ? S_EMIT : S_PUT;
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_COPY: begin
        cmd.wr_sel = WR_COPY;
        if (sts.cnt_copy_last) begin
          state_nxt = S_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_sel = WR_FILL;
        if (sts.cnt_last) begin
          state_nxt = sts.is_newline ? S_EMIT : S_PUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_PUT: begin
        cmd.wr_sel = WR_CHAR;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, sweep counter, result register.
`default_nettype none
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcw_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  input  wire tcw_pkg::cmd_t     cmd,
  output tcw_pkg::status_t       sts,
  output logic                   out_valid,
  output tcw_pkg::out_item_t     out_data
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data_r;
  in_item_t          req_r;
  logic [7:0]        attr_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  line_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              scrolled_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       wr_data;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] req_addr;
  logic              req_in_range;

  assign cur_addr = ADDR_W'(line_r) * COLS_A + ADDR_W'(col_r);
  assign req_addr = ADDR_W'(req_r.read_row) * COLS_A + ADDR_W'(req_r.read_col);
  assign req_in_range = (32'(req_r.read_row) < ROWS) && (32'(req_r.read_col) < COLUMNS);

  assign sts.is_read       = req_r.opcode;
  assign sts.is_newline    = (req_r.char_code == NEWLINE_CODE);
  assign sts.col_full      = (col_r == COL_W'(COLUMNS));
  assign sts.line_last     = (line_r == ROW_W'(ROWS - 1));
  assign sts.cnt_copy_last = (cnt_r == ADDR_W'(CELLS - COLUMNS));
  assign sts.cnt_last      = (cnt_r == ADDR_W'(CELLS - 1));

  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_addr = cnt_r;
    rd_addr = req_addr;
    wr_data = {attr_r, BLANK_CODE};
    case (cmd.wr_sel)
      WR_CLEAR: begin
        mem_we  = 1'b1;
        wr_data = {RESET_ATTR, BLANK_CODE};
      end
      WR_COPY: begin
        // read runs one row ahead; the registered word lands one cell behind
        mem_we  = (cnt_r != '0);
        wr_addr = cnt_r - ADDR_W'(1);
        wr_data = rd_data_r;
        mem_re  = !sts.cnt_copy_last;
        rd_addr = cnt_r + COLS_A;
      end
      WR_FILL: begin
        mem_we = 1'b1;
      end
      WR_CHAR: begin
        mem_we  = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr_r, req_r.char_code};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    if (cmd.rd_req) begin
      mem_re  = 1'b1;
      rd_addr = req_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_data;
    end
    if (cmd.emit) begin
      out_data_r.read_cell  <= (req_r.opcode && req_in_range) ? rd_data_r : 16'd0;
      out_data_r.cursor_col <= 7'(col_r);
      out_data_r.cursor_row <= 5'(line_r);
      out_data_r.scrolled   <= scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      col_r       <= '0;
      line_r      <= '0;
      cnt_r       <= '0;
      scrolled_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      if (cmd.latch_req) begin
        scrolled_r <= 1'b0;
      end else if (cmd.scroll_start) begin
        scrolled_r <= 1'b1;
      end
      if (cmd.brk_line) begin
        line_r <= line_r + ROW_W'(1);
        col_r  <= '0;
      end else if (cmd.scroll_start) begin
        col_r <= '0;
      end else if (cmd.wr_sel == WR_CHAR) begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// A request is latched on start and decoded; a put then writes its character, and each request ends in a result strobe.
// A new request is taken only while idle, which the block reaches as it strobes the previous result.
// A scroll copies each cell up one row, one copy per cycle, with one read and one write port, then blanks the last row.
// After reset a clearing pass over all COLUMNS*ROWS cells blanks the screen; busy stays high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire tcw_pkg::in_item_t  in_data,
  // result channel
  output logic                    out_valid,
  output tcw_pkg::out_item_t      out_data,
  // attribute register write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // attribute writes are always taken; the user must send them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // controller: sequences the clearing pass, request decode, scroll sweep and result strobe
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: screen memory, cursor, attribute, sweep counter and result register
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a taken request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted request");

  // every request passes through several states, so strobes never touch
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high two cycles running");

  // only writes (puts and newlines) scroll, and a write returns no cell
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.scrolled) |-> (out_data.read_cell == 16'd0))
    else $error("scrolled result carries a cell");

  // no result while the block is free and nothing was under way
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

endmodule
`default_nettype wire
